[rtl/hsl_pkg.sv]
// ----------------------------------------------------------------------------
// HSL to RGB conversion package
// Shared constants, sector codes and pipeline control types for the
// HSL to RGB converter.
// ----------------------------------------------------------------------------
package hsl_pkg;

   // Scale of the hue, saturation and lightness inputs.
   localparam int FULL_SCALE   = 240;
   localparam int SECTOR_STEPS = 40;
   localparam int HALF_SECTOR  = SECTOR_STEPS / 2;

   // Common denominator of chroma, secondary value and offset.
   localparam int DENOM        = FULL_SCALE * FULL_SCALE * SECTOR_STEPS;
   localparam int LIGHT_WEIGHT = DENOM / FULL_SCALE;

   // Widths of the internal quantities.
   localparam int CHAN_W   = 8;
   localparam int PROD_W   = 16;   // a * s, up to 57600
   localparam int WEIGHT_W = 6;    // 40 - d, up to 40
   localparam int NUM_W    = 23;   // numerators, up to 2304000 with headroom
   localparam int QUOT_W   = 16;   // numerator * 17 / 2048

   // 255 / 2304000 reduces to 17 / (2048 * 75). The division by 75 is a
   // multiplication by a rounded-up reciprocal; exact for quotients below
   // 2^22 / 71, well above the largest reachable value of 19125.
   localparam int CHANNEL_GAIN = 17;
   localparam int PRE_SHIFT    = 11;
   localparam int RECIP_75     = 55925;
   localparam int RECIP_SHIFT  = 22;
   localparam int RECIP_W      = 16;
   localparam int CHANNEL_MAX  = 255;

   // Number of register stages from request to response.
   localparam int NUM_STAGES = 6;

   // Hue sectors, 60 degrees each.
   typedef enum logic [2:0] {
      SEC_RED_YELLOW    = 3'd0,
      SEC_YELLOW_GREEN  = 3'd1,
      SEC_GREEN_CYAN    = 3'd2,
      SEC_CYAN_BLUE     = 3'd3,
      SEC_BLUE_MAGENTA  = 3'd4,
      SEC_MAGENTA_RED   = 3'd5
   } sector_type;

   // Load enables for the two register stages inside one pipeline module.
   typedef struct packed {
      logic load_first;
      logic load_second;
   } stage_ctl_type;

endpackage

[rtl/hsl_to_rgb_converter.sv]
// ----------------------------------------------------------------------------
// HSL to RGB converter
// Converts hue, saturation and lightness on the 0-240 scale into 8-bit
// red, green and blue with exact integer arithmetic.
// ----------------------------------------------------------------------------
// Usage:
//   A request carries hue, saturation and lightness on req_*; it is taken
//   on a rising clock edge with req_valid high and req_stall low. Hue from
//   240 to 255 wraps into the first sector; saturation and lightness above
//   240 count as 240. Each request gives exactly one response on rsp_*,
//   taken on an edge with rsp_valid high and rsp_stall low.
//   Throughput is one request per cycle while the receiver does not stall,
//   set by the six register stages (normalize, span product, component
//   numerators, channel routing and scaling, reciprocal multiply, clamp),
//   each of which takes a new request every cycle unless stalled.
//   When the receiver stalls, the response holds and the stages behind it
//   keep filling their empty slots; req_stall rises only once all six
//   stages hold requests. Synchronous reset empties the pipeline; no
//   response is pending afterward.
// ----------------------------------------------------------------------------
module hsl_to_rgb_converter (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_hue,
   input  logic [7:0] req_saturation,
   input  logic [7:0] req_lightness,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_red,
   output logic [7:0] rsp_green,
   output logic [7:0] rsp_blue
);
   import hsl_pkg::*;

   stage_ctl_type       front_ctl;
   stage_ctl_type       mix_ctl;
   stage_ctl_type       div_ctl;

   logic [PROD_W-1:0]   span_sat;
   logic [WEIGHT_W-1:0] weight;
   logic [7:0]          light;
   sector_type          sector;
   logic [QUOT_W-1:0]   red_quot;
   logic [QUOT_W-1:0]   green_quot;
   logic [QUOT_W-1:0]   blue_quot;

   // Valid tracking and stage enables.
   hsl_pipe_ctl u_pipe_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .front_ctl (front_ctl),
      .mix_ctl   (mix_ctl),
      .div_ctl   (div_ctl)
   );

   // Input normalization and span product.
   hsl_front u_front (
      .clock      (clock),
      .ctl        (front_ctl),
      .hue        (req_hue),
      .saturation (req_saturation),
      .lightness  (req_lightness),
      .span_sat   (span_sat),
      .weight     (weight),
      .light      (light),
      .sector     (sector)
   );

   // Component numerators, routing and first scaling step.
   hsl_mix u_mix (
      .clock      (clock),
      .ctl        (mix_ctl),
      .span_sat   (span_sat),
      .weight     (weight),
      .light      (light),
      .sector     (sector),
      .red_quot   (red_quot),
      .green_quot (green_quot),
      .blue_quot  (blue_quot)
   );

   // Final division and clamp, one unit per channel.
   hsl_div75 u_div_red (
      .clock (clock),
      .ctl   (div_ctl),
      .quot  (red_quot),
      .chan  (rsp_red)
   );

   hsl_div75 u_div_green (
      .clock (clock),
      .ctl   (div_ctl),
      .quot  (green_quot),
      .chan  (rsp_green)
   );

   hsl_div75 u_div_blue (
      .clock (clock),
      .ctl   (div_ctl),
      .quot  (blue_quot),
      .chan  (rsp_blue)
   );

endmodule

[rtl/hsl_pipe_ctl.sv]
// ----------------------------------------------------------------------------
// HSL pipeline control
// Tracks the valid bit of each pipeline stage and decides which stages
// advance, so that bubbles collapse and a stall loses no request.
// ----------------------------------------------------------------------------
module hsl_pipe_ctl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output hsl_pkg::stage_ctl_type front_ctl,
   output hsl_pkg::stage_ctl_type mix_ctl,
   output hsl_pkg::stage_ctl_type div_ctl
);
   import hsl_pkg::*;

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] advance;
   logic                  req_take;
   logic                  rsp_take;

   // A stage may load when it is empty or when its content moves on.
   always_comb begin
      advance[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || !rsp_stall;
      for (int i = NUM_STAGES - 2; i >= 0; i--) begin
         advance[i] = !valid_ff[i] || advance[i+1];
      end
   end

   // Next valid bits: a loading stage takes the valid bit of the stage before it.
   always_comb begin
      valid_in = valid_ff;
      if (advance[0]) begin
         valid_in[0] = req_valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
         if (advance[i]) begin
            valid_in[i] = valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !advance[0];
   assign rsp_valid = valid_ff[NUM_STAGES-1];
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid && !rsp_stall;

   assign front_ctl = '{load_first: advance[0], load_second: advance[1]};
   assign mix_ctl   = '{load_first: advance[2], load_second: advance[3]};
   assign div_ctl   = '{load_first: advance[4], load_second: advance[5]};

   // A request taken without a response leaving adds one item in flight.
   assert property (@(posedge clock) disable iff (reset)
      (req_take && !rsp_take) |=>
         ($countones(valid_ff) == $past($countones(valid_ff)) + 1))
      else $error("pipeline occupancy did not grow on a lone request");

   // A response leaving without a new request removes one item.
   assert property (@(posedge clock) disable iff (reset)
      (!req_take && rsp_take) |=>
         ($countones(valid_ff) + 1 == $past($countones(valid_ff))))
      else $error("pipeline occupancy did not shrink on a lone response");

   // Input is held off only when every stage is occupied.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&valid_ff))
      else $error("request stalled while the pipeline has a bubble");

   // Reset empties the pipeline.
   assert property (@(posedge clock)
      reset |=> (valid_ff == '0))
      else $error("pipeline not empty after reset");

endmodule

[rtl/hsl_front.sv]
// ----------------------------------------------------------------------------
// HSL front end
// First stage normalizes the inputs and finds the sector, the hue weight
// and the lightness span; second stage forms span times saturation.
// ----------------------------------------------------------------------------
module hsl_front (
   input  logic                                   clock,
   input  hsl_pkg::stage_ctl_type                 ctl,
   input  logic [7:0]                             hue,
   input  logic [7:0]                             saturation,
   input  logic [7:0]                             lightness,
   output logic [hsl_pkg::PROD_W-1:0]             span_sat,
   output logic [hsl_pkg::WEIGHT_W-1:0]           weight,
   output logic [7:0]                             light,
   output hsl_pkg::sector_type                    sector
);
   import hsl_pkg::*;

   logic [7:0]          hue_wrap;
   logic [7:0]          hue_mod;
   logic [7:0]          hue_dist;
   logic [8:0]          light_x2;
   logic [8:0]          light_dev;

   logic [7:0]          sat_in,    sat_ff;
   logic [7:0]          span_in,   span_ff;
   logic [7:0]          light_in,  light_ff;
   logic [WEIGHT_W-1:0] weight_in, weight_ff;
   sector_type          sector_in, sector_ff;

   logic [PROD_W-1:0]   span_sat_in, span_sat_ff;
   logic [7:0]          light2_ff;
   logic [WEIGHT_W-1:0] weight2_ff;
   sector_type          sector2_ff;

   // Wrap hue past the scale and saturate saturation and lightness.
   always_comb begin
      hue_wrap = (hue >= 8'(FULL_SCALE)) ? hue - 8'(FULL_SCALE) : hue;
      sat_in   = (saturation > 8'(FULL_SCALE)) ? 8'(FULL_SCALE) : saturation;
      light_in = (lightness > 8'(FULL_SCALE)) ? 8'(FULL_SCALE) : lightness;
   end

   // Sector is hue divided by 40; the weight is 40 minus the distance of
   // hue modulo 80 from the middle of the double sector.
   always_comb begin
      priority if (hue_wrap >= 8'(5 * SECTOR_STEPS)) begin
         sector_in = SEC_MAGENTA_RED;
      end else if (hue_wrap >= 8'(4 * SECTOR_STEPS)) begin
         sector_in = SEC_BLUE_MAGENTA;
      end else if (hue_wrap >= 8'(3 * SECTOR_STEPS)) begin
         sector_in = SEC_CYAN_BLUE;
      end else if (hue_wrap >= 8'(2 * SECTOR_STEPS)) begin
         sector_in = SEC_GREEN_CYAN;
      end else if (hue_wrap >= 8'(SECTOR_STEPS)) begin
         sector_in = SEC_YELLOW_GREEN;
      end else begin
         sector_in = SEC_RED_YELLOW;
      end

      priority if (hue_wrap >= 8'(4 * SECTOR_STEPS)) begin
         hue_mod = hue_wrap - 8'(4 * SECTOR_STEPS);
      end else if (hue_wrap >= 8'(2 * SECTOR_STEPS)) begin
         hue_mod = hue_wrap - 8'(2 * SECTOR_STEPS);
      end else begin
         hue_mod = hue_wrap;
      end

      hue_dist  = (hue_mod >= 8'(SECTOR_STEPS)) ? hue_mod - 8'(SECTOR_STEPS)
                                                : 8'(SECTOR_STEPS) - hue_mod;
      weight_in = WEIGHT_W'(8'(SECTOR_STEPS) - hue_dist);
   end

   // Lightness span: 240 minus the distance of twice lightness from 240.
   always_comb begin
      light_x2  = {light_in, 1'b0};
      light_dev = (light_x2 >= 9'(FULL_SCALE)) ? light_x2 - 9'(FULL_SCALE)
                                               : 9'(FULL_SCALE) - light_x2;
      span_in   = 8'(9'(FULL_SCALE) - light_dev);
   end

   // Second stage product of span and saturation.
   assign span_sat_in = PROD_W'(span_ff) * PROD_W'(sat_ff);

   always_ff @(posedge clock) begin
      if (ctl.load_first) begin
         sat_ff    <= sat_in;
         span_ff   <= span_in;
         light_ff  <= light_in;
         weight_ff <= weight_in;
         sector_ff <= sector_in;
      end
      if (ctl.load_second) begin
         span_sat_ff <= span_sat_in;
         light2_ff   <= light_ff;
         weight2_ff  <= weight_ff;
         sector2_ff  <= sector_ff;
      end
   end

   assign span_sat = span_sat_ff;
   assign weight   = weight2_ff;
   assign light    = light2_ff;
   assign sector   = sector2_ff;

endmodule

[rtl/hsl_mix.sv]
// ----------------------------------------------------------------------------
// HSL component mixer
// First stage forms chroma, secondary value and offset as numerators over
// 2304000; second stage routes them to the channels by sector and scales
// each channel numerator by 17 / 2048.
// ----------------------------------------------------------------------------
module hsl_mix (
   input  logic                             clock,
   input  hsl_pkg::stage_ctl_type           ctl,
   input  logic [hsl_pkg::PROD_W-1:0]       span_sat,
   input  logic [hsl_pkg::WEIGHT_W-1:0]     weight,
   input  logic [7:0]                       light,
   input  hsl_pkg::sector_type              sector,
   output logic [hsl_pkg::QUOT_W-1:0]       red_quot,
   output logic [hsl_pkg::QUOT_W-1:0]       green_quot,
   output logic [hsl_pkg::QUOT_W-1:0]       blue_quot
);
   import hsl_pkg::*;

   localparam int SCALED_W = NUM_W + 5;

   logic [NUM_W-1:0]    chroma_in,    chroma_ff;
   logic [NUM_W-1:0]    second_in,    second_ff;
   logic [NUM_W-1:0]    offset_in,    offset_ff;
   sector_type          sector_ff;

   logic [NUM_W-1:0]    red_part;
   logic [NUM_W-1:0]    green_part;
   logic [NUM_W-1:0]    blue_part;
   logic [NUM_W-1:0]    red_num;
   logic [NUM_W-1:0]    green_num;
   logic [NUM_W-1:0]    blue_num;
   logic [SCALED_W-1:0] red_scaled;
   logic [SCALED_W-1:0] green_scaled;
   logic [SCALED_W-1:0] blue_scaled;
   logic [QUOT_W-1:0]   red_in,   red_ff;
   logic [QUOT_W-1:0]   green_in, green_ff;
   logic [QUOT_W-1:0]   blue_in,  blue_ff;

   // Chroma is span_sat * 40, the secondary value span_sat * weight, and
   // the offset lightness * 9600 - span_sat * 20, never negative.
   always_comb begin
      chroma_in = NUM_W'(span_sat) * NUM_W'(SECTOR_STEPS);
      second_in = NUM_W'(span_sat) * NUM_W'(weight);
      offset_in = NUM_W'(light) * NUM_W'(LIGHT_WEIGHT)
                - NUM_W'(span_sat) * NUM_W'(HALF_SECTOR);
   end

   // Route chroma and secondary value to the channels of this sector.
   always_comb begin
      red_part   = '0;
      green_part = '0;
      blue_part  = '0;
      unique case (sector_ff)
         SEC_RED_YELLOW: begin
            red_part   = chroma_ff;
            green_part = second_ff;
         end
         SEC_YELLOW_GREEN: begin
            red_part   = second_ff;
            green_part = chroma_ff;
         end
         SEC_GREEN_CYAN: begin
            green_part = chroma_ff;
            blue_part  = second_ff;
         end
         SEC_CYAN_BLUE: begin
            green_part = second_ff;
            blue_part  = chroma_ff;
         end
         SEC_BLUE_MAGENTA: begin
            red_part   = second_ff;
            blue_part  = chroma_ff;
         end
         default: begin
            red_part   = chroma_ff;
            blue_part  = second_ff;
         end
      endcase
   end

   // Add the offset and take numerator * 17 / 2048, truncated.
   always_comb begin
      red_num      = red_part + offset_ff;
      green_num    = green_part + offset_ff;
      blue_num     = blue_part + offset_ff;
      red_scaled   = SCALED_W'(red_num) * SCALED_W'(CHANNEL_GAIN);
      green_scaled = SCALED_W'(green_num) * SCALED_W'(CHANNEL_GAIN);
      blue_scaled  = SCALED_W'(blue_num) * SCALED_W'(CHANNEL_GAIN);
      red_in       = red_scaled[PRE_SHIFT +: QUOT_W];
      green_in     = green_scaled[PRE_SHIFT +: QUOT_W];
      blue_in      = blue_scaled[PRE_SHIFT +: QUOT_W];
   end

   always_ff @(posedge clock) begin
      if (ctl.load_first) begin
         chroma_ff <= chroma_in;
         second_ff <= second_in;
         offset_ff <= offset_in;
         sector_ff <= sector;
      end
      if (ctl.load_second) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
      end
   end

   assign red_quot   = red_ff;
   assign green_quot = green_ff;
   assign blue_quot  = blue_ff;

endmodule

[rtl/hsl_div75.sv]
// ----------------------------------------------------------------------------
// HSL channel divider
// Divides one scaled channel value by 75 through a reciprocal multiply,
// then clamps the result to the 8-bit channel range.
// ----------------------------------------------------------------------------
module hsl_div75 (
   input  logic                          clock,
   input  hsl_pkg::stage_ctl_type        ctl,
   input  logic [hsl_pkg::QUOT_W-1:0]    quot,
   output logic [hsl_pkg::CHAN_W-1:0]    chan
);
   import hsl_pkg::*;

   localparam int MUL_W = QUOT_W + RECIP_W;
   localparam int HIGH_W = MUL_W - RECIP_SHIFT;

   logic [MUL_W-1:0]  prod_in, prod_ff;
   logic [HIGH_W-1:0] prod_high;
   logic [CHAN_W-1:0] chan_in, chan_ff;

   // First stage: multiply by the reciprocal of 75.
   assign prod_in = MUL_W'(quot) * MUL_W'(RECIP_75);

   // Second stage: drop the fraction and clamp to the channel maximum.
   always_comb begin
      prod_high = prod_ff[RECIP_SHIFT +: HIGH_W];
      if (prod_high > HIGH_W'(CHANNEL_MAX)) begin
         chan_in = CHAN_W'(CHANNEL_MAX);
      end else begin
         chan_in = prod_high[CHAN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_first) begin
         prod_ff <= prod_in;
      end
      if (ctl.load_second) begin
         chan_ff <= chan_in;
      end
   end

   assign chan = chan_ff;

endmodule

[tb/rgb_check_pkg.sv]
// ----------------------------------------------------------------------------
// HSL to RGB color checker
// Computes the expected red, green and blue for each accepted request in
// exact integer arithmetic and compares them with the converter's responses
// in order.
// ----------------------------------------------------------------------------
package rgb_check_pkg;

   import hsl_pkg::*;

   class rgb_scoreboard;

      // One expected color together with the request that caused it.
      typedef struct {
         logic [7:0] hue;
         logic [7:0] sat;
         logic [7:0] light;
         logic [7:0] red;
         logic [7:0] green;
         logic [7:0] blue;
      } rgb_color;

      rgb_color expected_colors[$];
      int       mismatches;

      function new();
         mismatches = 0;
      endfunction

      // Scale one channel numerator to 0..255, truncating toward zero.
      function logic [7:0] scale_channel(longint num);
         longint level;
         level = (num * CHANNEL_MAX) / DENOM;
         if (level < 0) level = 0;
         if (level > CHANNEL_MAX) level = CHANNEL_MAX;
         return level[7:0];
      endfunction

      // Exact conversion of one triple, with all numerators over DENOM.
      function rgb_color convert_hsl(logic [7:0] hue, logic [7:0] sat, logic [7:0] light);
         longint     h, s, l, deviation, span, prod, chroma, second, offset, r, g, b;
         sector_type sector;
         rgb_color   color;
         h = longint'(hue);
         s = longint'(sat);
         l = longint'(light);
         // Hue past the scale wraps; saturation and lightness saturate.
         if (h >= FULL_SCALE) h -= FULL_SCALE;
         if (s > FULL_SCALE) s = FULL_SCALE;
         if (l > FULL_SCALE) l = FULL_SCALE;

         deviation = 2 * l - FULL_SCALE;
         if (deviation < 0) deviation = -deviation;
         span = FULL_SCALE - deviation;

         deviation = (h % (2 * SECTOR_STEPS)) - SECTOR_STEPS;
         if (deviation < 0) deviation = -deviation;

         prod   = span * s;
         chroma = prod * SECTOR_STEPS;
         second = prod * (SECTOR_STEPS - deviation);
         offset = l * LIGHT_WEIGHT - prod * HALF_SECTOR;

         // Route chroma and the secondary value by hue sector.
         r = 0;
         g = 0;
         b = 0;
         sector = sector_type'(h / SECTOR_STEPS);
         unique case (sector)
            SEC_RED_YELLOW: begin
               r = chroma;
               g = second;
            end
            SEC_YELLOW_GREEN: begin
               r = second;
               g = chroma;
            end
            SEC_GREEN_CYAN: begin
               g = chroma;
               b = second;
            end
            SEC_CYAN_BLUE: begin
               g = second;
               b = chroma;
            end
            SEC_BLUE_MAGENTA: begin
               r = second;
               b = chroma;
            end
            default: begin
               r = chroma;
               b = second;
            end
         endcase

         color.hue   = hue;
         color.sat   = sat;
         color.light = light;
         color.red   = scale_channel(r + offset);
         color.green = scale_channel(g + offset);
         color.blue  = scale_channel(b + offset);
         return color;
      endfunction

      // Print one mismatch line and count it.
      task report(string msg);
         $display("MISMATCH at %0t: %s", $time, msg);
         mismatches++;
      endtask

      // Record the color that an accepted request must produce.
      function void note_request(logic [7:0] hue, logic [7:0] sat, logic [7:0] light);
         expected_colors.push_back(convert_hsl(hue, sat, light));
      endfunction

      // Compare one accepted response with the oldest expected color.
      task check_response(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
         rgb_color want;
         if (expected_colors.size() == 0) begin
            report($sformatf("response %0d/%0d/%0d with no request pending",
                             red, green, blue));
         end else begin
            want = expected_colors.pop_front();
            if (red !== want.red)
               report($sformatf("hsl %0d/%0d/%0d red %0d, expected %0d",
                                want.hue, want.sat, want.light, red, want.red));
            if (green !== want.green)
               report($sformatf("hsl %0d/%0d/%0d green %0d, expected %0d",
                                want.hue, want.sat, want.light, green, want.green));
            if (blue !== want.blue)
               report($sformatf("hsl %0d/%0d/%0d blue %0d, expected %0d",
                                want.hue, want.sat, want.light, blue, want.blue));
         end
      endtask

      function int pending();
         return expected_colors.size();
      endfunction

   endclass

endpackage

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// HSL to RGB converter testbench
// Drives directed corner triples and then random ones through the converter
// with random gaps and stalls on both channels, including a long receiver
// hold-off that fills the pipeline, and checks every response in order.
// ----------------------------------------------------------------------------
module tb_top;

   import hsl_pkg::*;
   import rgb_check_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_MIXED_A = 400;
   localparam int RANDOM_CALM    = 200;
   localparam int RANDOM_PRESSED = 60;
   localparam int RANDOM_MIXED_B = 765;
   localparam int HOLD_OFF_LEN   = 60;

   logic       clock;
   logic       reset          = 1'b1;
   logic       req_valid      = 1'b0;
   logic       req_stall;
   logic [7:0] req_hue        = 8'd0;
   logic [7:0] req_saturation = 8'd0;
   logic [7:0] req_lightness  = 8'd0;
   logic       rsp_valid;
   logic       rsp_stall      = 1'b0;
   logic [7:0] rsp_red;
   logic [7:0] rsp_green;
   logic [7:0] rsp_blue;

   // Phase controls set by the main sequence for the sender and the receiver.
   bit sender_calm  = 1'b0;
   bit rsp_calm     = 1'b0;
   int hold_off_len = 0;

   rgb_scoreboard board;

   hsl_to_rgb_converter uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_lightness  (req_lightness),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Idle length: mostly none or short, now and then long.
   function automatic int idle_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Saturation or lightness, with the scale ends and the saturating range.
   function automatic logic [7:0] pick_level();
      int roll;
      roll = $urandom_range(0, 19);
      if (roll == 0) return 8'd0;
      if (roll == 1) return 8'(FULL_SCALE);
      if (roll < 4) return 8'($urandom_range(FULL_SCALE + 1, 255));
      return 8'($urandom_range(0, FULL_SCALE));
   endfunction

   // Offer one request after an optional gap and wait until it is taken.
   task automatic send_request(input logic [7:0] hue, input logic [7:0] sat,
                               input logic [7:0] light);
      int gap;
      gap = sender_calm ? 0 : idle_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_hue        <= hue;
      req_saturation <= sat;
      req_lightness  <= light;
      req_valid      <= 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
      board.note_request(hue, sat, light);
   endtask

   task automatic send_random(input int count);
      repeat (count)
         send_request(8'($urandom_range(0, 255)), pick_level(), pick_level());
   endtask

   // Receiver: checks accepted responses and stalls at random, or holds off
   // for a long stretch when asked.
   initial begin : rsp_side
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0)
            board.check_response(rsp_red, rsp_green, rsp_blue);
         if (hold_off_len != 0) begin
            stall_left   = hold_off_len;
            hold_off_len = 0;
         end else if (stall_left == 0 && !rsp_calm) begin
            stall_left = idle_gap();
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: ends the run when nothing moves on either channel too long.
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   // Main sequence.
   initial begin
      board = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Primary and secondary colors, plus hues 20 and 239, at full saturation and mid lightness.
      send_request(8'd0,   8'd240, 8'd120);
      send_request(8'd40,  8'd240, 8'd120);
      send_request(8'd80,  8'd240, 8'd120);
      send_request(8'd120, 8'd240, 8'd120);
      send_request(8'd160, 8'd240, 8'd120);
      send_request(8'd200, 8'd240, 8'd120);
      send_request(8'd20,  8'd240, 8'd120);
      send_request(8'd239, 8'd240, 8'd120);
      // Hue past the scale wraps into the first sector.
      send_request(8'd240, 8'd240, 8'd120);
      send_request(8'd241, 8'd200, 8'd100);
      send_request(8'd255, 8'd240, 8'd120);
      // Saturation and lightness above the scale saturate.
      send_request(8'd60,  8'd241, 8'd120);
      send_request(8'd60,  8'd255, 8'd120);
      send_request(8'd100, 8'd240, 8'd241);
      send_request(8'd100, 8'd180, 8'd255);
      // Extremes of the fields, black, white and gray.
      send_request(8'd0,   8'd0,   8'd0);
      send_request(8'd255, 8'd255, 8'd255);
      send_request(8'd240, 8'd240, 8'd240);
      send_request(8'd140, 8'd240, 8'd0);
      send_request(8'd100, 8'd0,   8'd77);
      send_request(8'd17,  8'd123, 8'd1);
      send_request(8'd199, 8'd1,   8'd239);
      send_request(8'd79,  8'd240, 8'd119);
      send_request(8'd81,  8'd239, 8'd121);

      // Random triples with idling on both sides.
      send_random(RANDOM_MIXED_A);

      // A stretch with no idling at all.
      sender_calm = 1'b1;
      rsp_calm    = 1'b1;
      send_random(RANDOM_CALM);

      // The receiver holds off while requests keep coming; the pipeline
      // fills and pushes back on the request side.
      hold_off_len = HOLD_OFF_LEN;
      send_random(RANDOM_PRESSED);

      sender_calm = 1'b0;
      rsp_calm    = 1'b0;
      send_random(RANDOM_MIXED_B);
      req_valid <= 1'b0;

      // Drain, then keep watching for any stray response.
      while (board.pending() != 0) @(posedge clock);
      repeat (NUM_STAGES + 4) @(posedge clock);

      if (board.mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
